// ===== hw/rtl/arc_pkg.sv =====
// ----------------------------------------------------------------------------
// arc_pkg
// Shared types and constants for the aging replacement cache.
// ----------------------------------------------------------------------------
package arc_pkg;

	localparam int ENTRIES      = 8;
	localparam int AGE_BITS     = 16;
	localparam int PAYLOAD_BITS = 32;

	localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int FILL_W = $clog2(ENTRIES + 1);

	localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

	localparam logic [1:0] MODE_TICK   = 2'd0;
	localparam logic [1:0] MODE_INSERT = 2'd1;
	localparam logic [1:0] MODE_TOUCH  = 2'd2;

	typedef logic [AGE_BITS-1:0]     age_t;
	typedef logic [PAYLOAD_BITS-1:0] pay_t;
	typedef logic [FILL_W-1:0]       fill_t;
	typedef logic [IDX_W-1:0]        idx_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] payload;
		logic [2:0]  slot;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  chosen_slot;
		logic [31:0] stored_payload;
		logic [3:0]  filled_count;
		logic        valid_res;
	} rsp_t;

endpackage

// ===== hw/rtl/aging_replacement_cache.sv =====
// ----------------------------------------------------------------------------
// aging_replacement_cache
// Fully associative handle store with per-entry age counters: tick, insert
// with oldest-entry replacement, and touch on hit.
// ----------------------------------------------------------------------------
// Timing: done follows the start transfer through the input register, then the
//   result register; ages, payloads and fill count update as the result registers.
// Throughput: one command per cycle; busy stays low.
// Reset: arst_n clears fill count, ages and the pipeline valid flags; stored
//   payloads hold no reset value and are read only from filled entries.
// ----------------------------------------------------------------------------
module aging_replacement_cache
	import arc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  cmd_t cmd,
	output logic done,
	output rsp_t rsp
);

	logic  vld_s1;
	cmd_t  cmd_s1;
	age_t  age_q [ENTRIES];
	pay_t  pay_q [ENTRIES];
	fill_t fill_q;
	logic  done_q;
	rsp_t  rsp_q;

	idx_t  victim;
	age_t  best_age;
	idx_t  chosen;
	fill_t fill_nxt;
	logic  full;
	logic  touch_ok;
	idx_t  touch_idx;
	rsp_t  rsp_d;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cmd_s1 <= cmd;
		end
	end

	// lowest index of strictly greatest age; slot 0 when all zero
	always_comb begin
		victim   = '0;
		best_age = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (age_q[i] > best_age) begin
				best_age = age_q[i];
				victim   = idx_t'(i);
			end
		end
	end

	assign full      = (fill_q == fill_t'(ENTRIES));
	assign touch_idx = idx_t'(cmd_s1.slot);
	assign touch_ok  = ({{FILL_W{1'b0}}, cmd_s1.slot} < {3'b000, fill_q})
		&& ({{FILL_W{1'b0}}, cmd_s1.slot} < (FILL_W + 3)'(ENTRIES));

	always_comb begin
		chosen   = '0;
		fill_nxt = fill_q;
		rsp_d    = '{chosen_slot: 3'd0, stored_payload: 32'd0,
			filled_count: 4'd0, valid_res: 1'b1};
		case (cmd_s1.mode)
			MODE_INSERT: begin
				if (full) begin
					chosen = victim;
				end else begin
					chosen   = idx_t'(fill_q);
					fill_nxt = fill_q + fill_t'(1);
				end
				rsp_d.chosen_slot = 3'(chosen);
			end
			MODE_TOUCH: begin
				rsp_d.chosen_slot = cmd_s1.slot;
				if (touch_ok) begin
					rsp_d.stored_payload = 32'(pay_q[touch_idx]);
				end else begin
					rsp_d.valid_res = 1'b0;
				end
			end
			default: begin
			end
		endcase
		rsp_d.filled_count = 4'(fill_nxt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			done_q <= 1'b0;
			for (int i = 0; i < ENTRIES; i++) begin
				age_q[i] <= '0;
			end
		end else begin
			done_q <= vld_s1;
			if (vld_s1) begin
				fill_q <= fill_nxt;
				case (cmd_s1.mode)
					MODE_TICK: begin
						for (int i = 0; i < ENTRIES; i++) begin
							if ((FILL_W + 1)'(i) < {1'b0, fill_q} && age_q[i] != AGE_MAX) begin
								age_q[i] <= age_q[i] + age_t'(1);
							end
						end
					end
					MODE_INSERT: begin
						age_q[chosen] <= '0;
					end
					MODE_TOUCH: begin
						if (touch_ok) begin
							age_q[touch_idx] <= '0;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1 && cmd_s1.mode == MODE_INSERT) begin
			pay_q[chosen] <= pay_t'(cmd_s1.payload);
		end
		if (vld_s1) begin
			rsp_q <= rsp_d;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// ===== hw/rtl/arc_checker.sv =====
// ----------------------------------------------------------------------------
// arc_checker
// Port-level checks for the aging replacement cache, bound to the top level.
// ----------------------------------------------------------------------------
module arc_checker
	import arc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input cmd_t cmd,
	input logic done,
	input rsp_t rsp
);

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 done)
		else $error("missing result two cycles after start transfer");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.filled_count <= 4'(ENTRIES)))
		else $error("filled count beyond capacity");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !rsp.valid_res) |-> (rsp.stored_payload == 32'd0))
		else $error("invalid touch returned a payload");

	a_touch_echo: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd.mode == MODE_TOUCH) |=> ##1
		(rsp.chosen_slot == $past(cmd.slot, 2)))
		else $error("touch result names another slot");

endmodule

bind aging_replacement_cache arc_checker u_arc_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.cmd    (cmd),
	.done   (done),
	.rsp    (rsp)
);

// ===== sim/aging_replacement_cache_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aging_replacement_cache_tb
// Sends tick, insert, touch and unused-mode commands to the age-counter cache.
// A local copy of ages, handles and fill count predicts every response, and
// each response is compared field by field with the oldest prediction.
// Covered: touches of empty slots, filling the store in order, and victim
// choice with all ages zero and with tied ages.
// ----------------------------------------------------------------------------
module aging_replacement_cache_tb;
	import arc_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int RANDOM_CMDS = 1920;
	localparam int CALM_TAIL = 300;
	localparam int AGING_TICKS = 12;

	class cache_scoreboard;
		age_t        ages [ENTRIES];
		pay_t        handles [ENTRIES];
		int unsigned fill;
		rsp_t        expected_rsp [$];
		int unsigned errors;

		function new();
			for (int i = 0; i < ENTRIES; i++) begin
				ages[i] = '0;
				handles[i] = '0;
			end
			fill = 0;
			errors = 0;
		endfunction

		task report(input string what);
			errors++;
			$display("%0t ns: mismatch: %s", $time, what);
		endtask

		task take_command(input cmd_t c);
			rsp_t        r;
			int unsigned pick;
			age_t        top;
			r = '0;
			r.valid_res = 1'b1;
			case (c.mode)
				MODE_TICK: begin
					for (int i = 0; i < fill; i++)
						if (ages[i] != AGE_MAX)
							ages[i] = ages[i] + 1'b1;
				end
				MODE_INSERT: begin
					if (fill < ENTRIES) begin
						pick = fill;
						fill++;
					end else begin
						pick = 0;
						top = '0;
						for (int i = 0; i < ENTRIES; i++)
							if (ages[i] > top) begin
								top = ages[i];
								pick = i;
							end
					end
					handles[pick] = pay_t'(c.payload);
					ages[pick] = '0;
					r.chosen_slot = 3'(pick);
				end
				MODE_TOUCH: begin
					r.chosen_slot = c.slot;
					if (c.slot < fill) begin
						ages[c.slot] = '0;
						r.stored_payload = 32'(handles[c.slot]);
					end else begin
						r.valid_res = 1'b0;
					end
				end
				default: ;
			endcase
			r.filled_count = 4'(fill);
			expected_rsp.push_back(r);
		endtask

		task compare_response(input rsp_t got);
			rsp_t want;
			if (expected_rsp.size() == 0) begin
				report($sformatf("response with nothing outstanding: %h", got));
				return;
			end
			want = expected_rsp.pop_front();
			if (got.chosen_slot !== want.chosen_slot)
				report($sformatf("chosen_slot %0d, want %0d", got.chosen_slot,
					want.chosen_slot));
			if (got.stored_payload !== want.stored_payload)
				report($sformatf("stored_payload %h, want %h", got.stored_payload,
					want.stored_payload));
			if (got.filled_count !== want.filled_count)
				report($sformatf("filled_count %0d, want %0d", got.filled_count,
					want.filled_count));
			if (got.valid_res !== want.valid_res)
				report($sformatf("valid_res %b, want %b", got.valid_res, want.valid_res));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	cmd_t cmd;
	rsp_t rsp;

	cache_scoreboard sb;
	int unsigned     cycles = 0;
	bit              idling;

	aging_replacement_cache dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.rsp    (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && done)
			sb.compare_response(rsp);

	task automatic send(input logic [1:0] mode, input logic [31:0] payload,
		input logic [2:0] slot);
		cmd_t c;
		c.mode = mode;
		c.payload = payload;
		c.slot = slot;
		start <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.take_command(c);
	endtask

	task automatic pause(input int unsigned n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.expected_rsp.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int unsigned pct;
		logic [1:0]  mode;
		logic [31:0] payload;
		int          n;
		sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty store: ticks, touches and the unused mode change nothing
		send(MODE_TICK, 32'hFFFF_FFFF, 3'd7);
		send(MODE_TOUCH, 32'h0, 3'd0);
		send(MODE_TOUCH, 32'hFFFF_FFFF, 3'd7);
		send(MODE_UNUSED, 32'hFFFF_FFFF, 3'd7);
		send(MODE_INSERT, 32'h0, 3'd7);
		send(MODE_TICK, 32'h0, 3'd0);
		send(MODE_TOUCH, 32'h0, 3'd1);
		send(MODE_TOUCH, 32'h0, 3'd0);
		send(MODE_INSERT, 32'hFFFF_FFFF, 3'd0);
		for (int i = 2; i < ENTRIES; i++)
			send(MODE_INSERT, $urandom(), 3'(i));
		send(MODE_TOUCH, 32'h0, 3'd7);
		// full with all ages zero: replace slot 0
		send(MODE_INSERT, 32'hA5A5_5A5A, 3'd0);
		send(MODE_TICK, 32'h0, 3'd0);
		send(MODE_TICK, 32'h0, 3'd0);
		send(MODE_TOUCH, 32'h0, 3'd3);
		send(MODE_INSERT, 32'h5A5A_A5A5, 3'd0);
		send(MODE_UNUSED, 32'h0, 3'd0);

		// age every entry
		for (int i = 0; i < AGING_TICKS; i++)
			send(MODE_TICK, $urandom(), 3'($urandom_range(7)));
		send(MODE_INSERT, $urandom(), 3'd0);
		send(MODE_TOUCH, $urandom(), 3'd5);
		send(MODE_INSERT, $urandom(), 3'd0);
		drain();

		for (int i = 0; i < RANDOM_CMDS; i++) begin
			if (i % 100 == 0)
				idling = ($urandom_range(2) != 0) && (i < RANDOM_CMDS - CALM_TAIL);
			if (i == RANDOM_CMDS / 2)
				drain();
			else if (idling && $urandom_range(3) == 0)
				pause($urandom_range(1, 9));
			pct = $urandom_range(99);
			if (pct < 35)
				mode = MODE_TICK;
			else if (pct < 65)
				mode = MODE_INSERT;
			else if (pct < 95)
				mode = MODE_TOUCH;
			else
				mode = MODE_UNUSED;
			case ($urandom_range(7))
				0: payload = 32'h0;
				1: payload = 32'hFFFF_FFFF;
				default: payload = $urandom();
			endcase
			send(mode, payload, 3'($urandom_range(7)));
		end
		start <= 1'b0;

		for (n = 0; n < 200 && sb.expected_rsp.size() != 0; n++)
			@(posedge clk);
		if (sb.expected_rsp.size() != 0)
			sb.report($sformatf("%0d responses never arrived", sb.expected_rsp.size()));
		repeat (4) @(posedge clk);
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
